>>> hw/rtl/gdg_pkg.sv
// Shared types, codes and defaults of the gather descriptor generator.
package gdg_pkg;

  localparam int DIM_WIDTH_DEF    = 16;
  localparam int OFFSET_WIDTH_DEF = 48;

  localparam int INDEX_WIDTH    = 64;
  localparam int CFG_WIDTH      = 16;
  localparam int CFG_ADDR_WIDTH = 3;

  typedef enum logic [CFG_ADDR_WIDTH-1:0] {
    REG_OUTER_COUNT    = 3'd0,
    REG_AXIS_LENGTH    = 3'd1,
    REG_INNER_LENGTH   = 3'd2,
    REG_INDEX_COUNT    = 3'd3,
    REG_NARROW_INDICES = 3'd4
  } reg_addr_t;

  localparam logic [CFG_WIDTH-1:0] OUTER_COUNT_RST  = 16'd1;
  localparam logic [CFG_WIDTH-1:0] AXIS_LENGTH_RST  = 16'd1;
  localparam logic [CFG_WIDTH-1:0] INNER_LENGTH_RST = 16'd1;
  localparam logic [CFG_WIDTH-1:0] INDEX_COUNT_RST  = 16'd1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_CLAMP = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // capture index, form base products, advance counters
    logic sum_en;    // add index and position to the base products
    logic out_load;  // scale by run length into the output register
  } gdg_cmd_t;

endpackage

>>> hw/rtl/gdg_ctrl.sv
// Controller of the gather descriptor generator: sequencing and handshakes.
module gdg_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output gdg_pkg::gdg_cmd_t cmd
);
  import gdg_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SUM,
    S_MUL
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   load_ok;
  logic   take_ok;

  // The output register can be loaded when empty or being taken now.
  assign load_ok  = !out_valid_r || !out_stall;
  assign take_ok  = (state_r == S_IDLE) || ((state_r == S_MUL) && load_ok);
  assign in_stall = !take_ok;

  assign cmd.accept   = in_valid && take_ok;
  assign cmd.sum_en   = (state_r == S_SUM);
  assign cmd.out_load = (state_r == S_MUL) && load_ok;

  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = cmd.out_load ? 1'b1 : (out_valid_r && out_stall);
    unique case (state_r)
      S_IDLE: begin
        if (cmd.accept) state_nxt = S_SUM;
      end
      S_SUM: begin
        state_nxt = S_MUL;
      end
      S_MUL: begin
        if (load_ok) state_nxt = cmd.accept ? S_SUM : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTH
  a_accept_to_sum: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> state_r == S_SUM)
    else $error("accepted transaction did not enter the sum step");

  a_sum_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SUM |=> state_r == S_MUL)
    else $error("sum step did not advance to the multiply step");

  a_load_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> state_r == S_MUL)
    else $error("output loaded outside the multiply step");

  a_valid_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_MUL))
    else $error("result appeared without a multiply step");
`endif

endmodule

>>> hw/rtl/gdg_datapath.sv
// Datapath of the gather descriptor generator: registers, counters, offsets.
module gdg_datapath #(
  parameter int DIM_WIDTH    = gdg_pkg::DIM_WIDTH_DEF,
  parameter int OFFSET_WIDTH = gdg_pkg::OFFSET_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  gdg_pkg::gdg_cmd_t                   cmd,
  input  logic                                cfg_we,
  input  logic [gdg_pkg::CFG_ADDR_WIDTH-1:0]  cfg_addr,
  input  logic [gdg_pkg::CFG_WIDTH-1:0]       cfg_data,
  input  logic signed [gdg_pkg::INDEX_WIDTH-1:0] in_index_value,
  output logic [OFFSET_WIDTH-1:0]             out_source_offset,
  output logic [OFFSET_WIDTH-1:0]             out_dest_offset,
  output logic [1:0]                          out_status,
  output logic                                out_last_item
);
  import gdg_pkg::*;

  localparam int PW = DIM_WIDTH + CFG_WIDTH;      // base product width
  localparam int SW = PW + 1;                     // base plus offset
  localparam int CW = (DIM_WIDTH > CFG_WIDTH) ? DIM_WIDTH : CFG_WIDTH;
  localparam int MW = OFFSET_WIDTH + CFG_WIDTH;   // scaled product width

  // Configuration registers.
  logic [CFG_WIDTH-1:0] outer_count_r, axis_length_r, inner_length_r, index_count_r;
  logic                 narrow_r;

  // Position counters.
  logic [DIM_WIDTH-1:0] outer_pos_r, outer_pos_nxt;
  logic [DIM_WIDTH-1:0] index_pos_r, index_pos_nxt;

  // First stage.
  logic [PW-1:0]        base_src_r, base_dst_r;
  logic [CFG_WIDTH-1:0] idx_r, idx_nxt;
  logic [DIM_WIDTH-1:0] pos_r;
  status_t              st1_r, st1_nxt;
  logic                 last1_r, last1_nxt;

  // Second stage.
  logic [OFFSET_WIDTH-1:0] sum_src_r, sum_dst_r;
  status_t                 st2_r;
  logic                    last2_r;

  // Output register.
  logic [OFFSET_WIDTH-1:0] src_r, dst_r;
  status_t                 st_out_r;
  logic                    last_out_r;

  logic signed [INDEX_WIDTH-1:0] idx_sel, idx_adj;
  logic [CFG_WIDTH-1:0]          ocnt, icnt;
  logic                          idx_end, out_end;
  logic [SW-1:0]                 sum_src, sum_dst;
  logic [MW-1:0]                 mul_src, mul_dst;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outer_count_r  <= OUTER_COUNT_RST;
      axis_length_r  <= AXIS_LENGTH_RST;
      inner_length_r <= INNER_LENGTH_RST;
      index_count_r  <= INDEX_COUNT_RST;
      narrow_r       <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_OUTER_COUNT:    outer_count_r  <= cfg_data;
        REG_AXIS_LENGTH:    axis_length_r  <= cfg_data;
        REG_INNER_LENGTH:   inner_length_r <= cfg_data;
        REG_INDEX_COUNT:    index_count_r  <= cfg_data;
        REG_NARROW_INDICES: narrow_r       <= cfg_data[0];
        default:            ;
      endcase
    end
  end

  // Normalize the index: add the axis length if negative, clamp if outside.
  always_comb begin
    idx_sel = narrow_r ? {{32{in_index_value[31]}}, in_index_value[31:0]}
                       : in_index_value;
    idx_adj = idx_sel[INDEX_WIDTH-1]
            ? idx_sel + $signed({{(INDEX_WIDTH-CFG_WIDTH){1'b0}}, axis_length_r})
            : idx_sel;
    idx_nxt = '0;
    st1_nxt = ST_OK;
    if (axis_length_r == '0) begin
      st1_nxt = ST_EMPTY;
    end else if (idx_adj[INDEX_WIDTH-1] ||
                 (idx_adj >= $signed({{(INDEX_WIDTH-CFG_WIDTH){1'b0}}, axis_length_r}))) begin
      st1_nxt = ST_CLAMP;
    end else begin
      idx_nxt = idx_adj[CFG_WIDTH-1:0];
    end
  end

  // A zero count acts as one; a counter at or past its count minus one is at its end.
  always_comb begin
    ocnt      = (outer_count_r == '0) ? CFG_WIDTH'(1) : outer_count_r;
    icnt      = (index_count_r == '0) ? CFG_WIDTH'(1) : index_count_r;
    idx_end   = CW'(index_pos_r) >= CW'(icnt - CFG_WIDTH'(1));
    out_end   = CW'(outer_pos_r) >= CW'(ocnt - CFG_WIDTH'(1));
    last1_nxt = idx_end && out_end;
    if (idx_end) begin
      index_pos_nxt = '0;
      outer_pos_nxt = out_end ? '0 : outer_pos_r + DIM_WIDTH'(1);
    end else begin
      index_pos_nxt = index_pos_r + DIM_WIDTH'(1);
      outer_pos_nxt = outer_pos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outer_pos_r <= '0;
      index_pos_r <= '0;
    end else if (cmd.accept) begin
      outer_pos_r <= outer_pos_nxt;
      index_pos_r <= index_pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      base_src_r <= PW'(outer_pos_r) * PW'(axis_length_r);
      base_dst_r <= PW'(outer_pos_r) * PW'(index_count_r);
      idx_r      <= idx_nxt;
      pos_r      <= index_pos_r;
      st1_r      <= st1_nxt;
      last1_r    <= last1_nxt;
    end
  end

  assign sum_src = SW'(base_src_r) + SW'(idx_r);
  assign sum_dst = SW'(base_dst_r) + SW'(pos_r);

  always_ff @(posedge clk) begin
    if (cmd.sum_en) begin
      sum_src_r <= OFFSET_WIDTH'(sum_src);
      sum_dst_r <= OFFSET_WIDTH'(sum_dst);
      st2_r     <= st1_r;
      last2_r   <= last1_r;
    end
  end

  assign mul_src = MW'(sum_src_r) * MW'(inner_length_r);
  assign mul_dst = MW'(sum_dst_r) * MW'(inner_length_r);

  // Offsets wrap to the offset width; an empty axis gives no copy.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      src_r      <= (st2_r == ST_EMPTY) ? '0 : mul_src[OFFSET_WIDTH-1:0];
      dst_r      <= (st2_r == ST_EMPTY) ? '0 : mul_dst[OFFSET_WIDTH-1:0];
      st_out_r   <= st2_r;
      last_out_r <= last2_r;
    end
  end

  assign out_source_offset = src_r;
  assign out_dest_offset   = dst_r;
  assign out_status        = st_out_r;
  assign out_last_item     = last_out_r;

endmodule

>>> hw/rtl/gather_descriptor_generator_unit.sv
// Top level of the gather descriptor generator: controller plus datapath.
//
// Usage: one signed gather index enters per in_ transaction, in outer-major
// order, the whole index list resent once for each outer slice. For each
// index one out_ transaction carries the source and destination element
// offsets of a run of inner_length elements, a status code (ok, clamped,
// empty axis) and a flag on the last index of the last outer slice.
// Steps: the edge that accepts an index normalizes it and registers the base
// products, the add step then adds index and position, and the multiply step
// scales by the run length into the output register.
// Flow: an index is taken while idle or in the same cycle that the output
// register is reloaded, so the next index waits for the add and the scaling
// multiply of the one before it.
// Stall: while out_stall holds a result, the finished next result waits in
// the multiply step and in_stall rises; nothing is lost or repeated.
// Configuration: cfg_ready is always high; write registers only while idle.
// Reset (rst_n low, synchronous): counters go to zero, registers to their
// defaults, all stages empty.
module gather_descriptor_generator_unit #(
  parameter int DIM_WIDTH    = gdg_pkg::DIM_WIDTH_DEF,
  parameter int OFFSET_WIDTH = gdg_pkg::OFFSET_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [gdg_pkg::INDEX_WIDTH-1:0] in_index_value,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [OFFSET_WIDTH-1:0]                out_source_offset,
  output logic [OFFSET_WIDTH-1:0]                out_dest_offset,
  output logic [1:0]                             out_status,
  output logic                                   out_last_item,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [gdg_pkg::CFG_ADDR_WIDTH-1:0]     cfg_addr,
  input  logic [gdg_pkg::CFG_WIDTH-1:0]          cfg_data
);
  import gdg_pkg::*;

  gdg_cmd_t cmd;

  assign cfg_ready = 1'b1;

  gdg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  gdg_datapath #(
    .DIM_WIDTH    (DIM_WIDTH),
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_addr          (cfg_addr),
    .cfg_data          (cfg_data),
    .in_index_value    (in_index_value),
    .out_source_offset (out_source_offset),
    .out_dest_offset   (out_dest_offset),
    .out_status        (out_status),
    .out_last_item     (out_last_item)
  );

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for the gather descriptor generator unit.
`timescale 1ns / 1ps

module tb_top;
  import gdg_pkg::*;

  localparam int OFFSET_W       = OFFSET_WIDTH_DEF;
  localparam int STALL_LIMIT    = 2000;
  localparam int RANDOM_ITEMS   = 1120;
  localparam int IDLE_PCT       = 12;
  localparam logic [CFG_ADDR_WIDTH-1:0] REG_UNMAPPED_LO = 3'd5;
  localparam logic [CFG_ADDR_WIDTH-1:0] REG_UNMAPPED_HI = 3'd7;

  typedef struct {
    logic [OFFSET_W-1:0] source_offset;
    logic [OFFSET_W-1:0] dest_offset;
    status_t             status;
    logic                last_item;
  } descriptor_t;

  logic                         clk;
  logic                         rst_n          = 1'b0;
  logic                         in_valid       = 1'b0;
  logic                         in_stall;
  logic signed [INDEX_WIDTH-1:0] in_index_value = '0;
  logic                         out_valid;
  logic                         out_stall      = 1'b0;
  logic [OFFSET_W-1:0]          out_source_offset;
  logic [OFFSET_W-1:0]          out_dest_offset;
  logic [1:0]                   out_status;
  logic                         out_last_item;
  logic                         cfg_valid      = 1'b0;
  logic                         cfg_ready;
  logic [CFG_ADDR_WIDTH-1:0]    cfg_addr       = '0;
  logic [CFG_WIDTH-1:0]         cfg_data       = '0;

  // Register mirror and slice counters of the predictor
  logic [CFG_WIDTH-1:0] outer_count_reg  = OUTER_COUNT_RST;
  logic [CFG_WIDTH-1:0] axis_length_reg  = AXIS_LENGTH_RST;
  logic [CFG_WIDTH-1:0] inner_length_reg = INNER_LENGTH_RST;
  logic [CFG_WIDTH-1:0] index_count_reg  = INDEX_COUNT_RST;
  logic                 narrow_reg       = 1'b0;
  logic [15:0]          outer_pos        = '0;
  logic [15:0]          index_pos        = '0;

  descriptor_t pending_descriptors[$];
  int          mismatch_count  = 0;
  int          gap_pct         = IDLE_PCT;
  int          stall_pct       = IDLE_PCT;
  int          hold_off_cycles = 0;

  gather_descriptor_generator_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_index_value   (in_index_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_source_offset(out_source_offset),
    .out_dest_offset  (out_dest_offset),
    .out_status       (out_status),
    .out_last_item    (out_last_item),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_addr         (cfg_addr),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void apply_register(input logic [CFG_ADDR_WIDTH-1:0] addr,
                                         input logic [CFG_WIDTH-1:0] data);
    case (addr)
      REG_OUTER_COUNT:    outer_count_reg  = data;
      REG_AXIS_LENGTH:    axis_length_reg  = data;
      REG_INNER_LENGTH:   inner_length_reg = data;
      REG_INDEX_COUNT:    index_count_reg  = data;
      REG_NARROW_INDICES: narrow_reg       = data[0];
      default: ;
    endcase
  endfunction

  // Work out the descriptor for one index and advance the slice counters.
  function automatic descriptor_t predict_descriptor(input logic [INDEX_WIDTH-1:0] raw);
    descriptor_t d;
    longint      idx;
    longint      ax;
    int          ocnt;
    int          icnt;
    logic [63:0] src_full;
    logic [63:0] dst_full;
    logic        slice_end;
    logic        sweep_end;
    ax   = longint'(axis_length_reg);
    ocnt = (outer_count_reg == 0) ? 1 : int'(outer_count_reg);
    icnt = (index_count_reg == 0) ? 1 : int'(index_count_reg);
    slice_end = int'(index_pos) >= icnt - 1;
    sweep_end = int'(outer_pos) >= ocnt - 1;
    if (narrow_reg) begin
      idx = {{32{raw[31]}}, raw[31:0]};
    end else begin
      idx = raw;
    end
    d.status = ST_OK;
    src_full = '0;
    dst_full = '0;
    if (ax == 0) begin
      d.status = ST_EMPTY;
    end else begin
      if (idx < 0) idx += ax;
      if (idx < 0 || idx >= ax) begin
        idx      = 0;
        d.status = ST_CLAMP;
      end
      src_full = (longint'(outer_pos) * ax + idx) * longint'(inner_length_reg);
      dst_full = (longint'(outer_pos) * longint'(index_count_reg) + longint'(index_pos))
                 * longint'(inner_length_reg);
    end
    d.source_offset = src_full[OFFSET_W-1:0];
    d.dest_offset   = dst_full[OFFSET_W-1:0];
    d.last_item     = slice_end && sweep_end;
    if (slice_end) begin
      index_pos = '0;
      outer_pos = sweep_end ? 16'd0 : outer_pos + 16'd1;
    end else begin
      index_pos = index_pos + 16'd1;
    end
    return d;
  endfunction

  // Mostly in-range indices for the current axis, some clamps and raw noise.
  function automatic logic [INDEX_WIDTH-1:0] pick_index();
    longint v;
    int     roll;
    int     ax;
    ax   = int'(axis_length_reg);
    roll = $urandom_range(99);
    if (roll >= 90 || ax == 0) return {$urandom, $urandom};
    if (roll < 60) begin
      v = longint'($urandom_range(ax - 1));
    end else if (roll < 80) begin
      v = -longint'($urandom_range(ax, 1));
    end else if (roll < 85) begin
      v = longint'(ax) + longint'($urandom_range(3));
    end else begin
      v = -(longint'(ax) + 64'sd1 + longint'($urandom_range(3)));
    end
    if (narrow_reg) return {$urandom, v[31:0]};
    return v;
  endfunction

  function automatic logic [CFG_WIDTH-1:0] pick_dim(input int small_max);
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) return '0;
    if (roll < 20) return 16'hFFFF;
    if (roll < 30) return CFG_WIDTH'($urandom_range(16'hFFFF));
    return CFG_WIDTH'($urandom_range(small_max, 1));
  endfunction

  // Send one index; returns at the falling edge after the transaction.
  task automatic send_index(input logic [INDEX_WIDTH-1:0] value);
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_index_value <= value;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_descriptors.push_back(predict_descriptor(value));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_descriptors.size() != 0);
  endtask

  task automatic write_register(input logic [CFG_ADDR_WIDTH-1:0] addr,
                                input logic [CFG_WIDTH-1:0] data);
    cfg_valid <= 1'b1;
    cfg_addr  <= addr;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    apply_register(addr, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic program_shape(input logic [CFG_WIDTH-1:0] outer, input logic [CFG_WIDTH-1:0] axis,
                               input logic [CFG_WIDTH-1:0] inner, input logic [CFG_WIDTH-1:0] icnt,
                               input logic [CFG_WIDTH-1:0] narrow);
    wait_drained();
    write_register(REG_OUTER_COUNT, outer);
    write_register(REG_AXIS_LENGTH, axis);
    write_register(REG_INNER_LENGTH, inner);
    write_register(REG_INDEX_COUNT, icnt);
    write_register(REG_NARROW_INDICES, narrow);
  endtask

  task automatic randomize_shape();
    program_shape(pick_dim(4), pick_dim(16), pick_dim(16), pick_dim(8),
                  CFG_WIDTH'($urandom_range(16'hFFFF)));
    if ($urandom_range(9) == 0) begin
      write_register(REG_UNMAPPED_HI, CFG_WIDTH'($urandom_range(16'hFFFF)));
    end
  endtask

  task automatic test_reset_defaults();
    send_index(64'sd0);
    send_index(-64'sd1);
    send_index(64'sd1);
    send_index(64'h8000_0000_0000_0000);
  endtask

  task automatic test_index_extremes();
    program_shape(16'd2, 16'd10, 16'd3, 16'd4, 16'd0);
    send_index(64'sd9);
    send_index(-64'sd10);
    send_index(-64'sd11);
    send_index(64'sd10);
    send_index(64'h7FFF_FFFF_FFFF_FFFF);
    // upper bits set on the narrow setting must not clear the flag
    wait_drained();
    write_register(REG_NARROW_INDICES, 16'hFFFF);
    send_index(64'hFFFF_FFFF_0000_0005);
    send_index(64'h0000_0000_FFFF_FFFF);
    send_index(64'h7FFF_FFFF_8000_0000);
    send_index(64'h8000_0000_7FFF_FFFF);
    wait_drained();
    write_register(REG_NARROW_INDICES, 16'hFFFE);
  endtask

  task automatic test_empty_axis();
    program_shape(16'd3, 16'd0, 16'd7, 16'd2, 16'd0);
    send_index(64'sd0);
    send_index(-64'sd1);
  endtask

  task automatic test_zero_counts();
    program_shape(16'd0, 16'd4, 16'd0, 16'd0, 16'd1);
    write_register(REG_UNMAPPED_LO, 16'hFFFF);
    write_register(REG_UNMAPPED_HI, 16'h0000);
    send_index(64'sd2);
    send_index(-64'sd2);
  endtask

  task automatic test_count_lowered();
    program_shape(16'd4, 16'd16, 16'd5, 16'd8, 16'd0);
    repeat (4) send_index(pick_index());
    // shrink the slice while the index counter sits past the new end
    wait_drained();
    write_register(REG_INDEX_COUNT, 16'd2);
    repeat (2) send_index(pick_index());
  endtask

  task automatic test_largest_shape();
    program_shape(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
    send_index(64'sd65534);
    send_index(-64'sd65535);
    send_index(64'sd65535);
  endtask

  task automatic test_back_to_back();
    gap_pct   = 0;
    stall_pct = 0;
    program_shape(16'd3, 16'd12, 16'd9, 16'd5, 16'd0);
    repeat (200) send_index(pick_index());
    gap_pct   = IDLE_PCT;
    stall_pct = IDLE_PCT;
  endtask

  task automatic test_output_backpressure();
    program_shape(16'd2, 16'd20, 16'd6, 16'd7, 16'd1);
    hold_off_cycles = 120;
    repeat (40) send_index(pick_index());
  endtask

  task automatic test_sender_pause();
    randomize_shape();
    repeat (30) send_index(pick_index());
    wait_drained();
    repeat (30) send_index(pick_index());
  endtask

  task automatic test_random_traffic();
    int sent;
    int burst;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      randomize_shape();
      burst = $urandom_range(80, 20);
      repeat (burst) send_index(pick_index());
      sent += burst;
    end
  endtask

  // Result sink: random stalls plus the long hold-off of the backpressure test.
  initial begin : result_sink
    forever begin
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        out_stall <= 1'b1;
        hold_off_cycles--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic compare_field(input string name, input logic [63:0] expected_value,
                               input logic [63:0] actual_value);
    if (actual_value !== expected_value) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, expected_value, actual_value);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    descriptor_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (pending_descriptors.size() == 0) begin
        $error("descriptor transaction with nothing pending");
        mismatch_count++;
      end else begin
        want = pending_descriptors.pop_front();
        compare_field("source_offset", want.source_offset, out_source_offset);
        compare_field("dest_offset", want.dest_offset, out_dest_offset);
        compare_field("status", want.status, out_status);
        compare_field("last_item", want.last_item, out_last_item);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
          (cfg_valid && cfg_ready === 1'b1)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : test_sequence
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_defaults();
    test_index_extremes();
    test_empty_axis();
    test_zero_counts();
    test_count_lowered();
    test_largest_shape();
    test_back_to_back();
    test_output_backpressure();
    test_sender_pause();
    test_random_traffic();
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/gdg_pkg.sv
hw/rtl/gdg_ctrl.sv
hw/rtl/gdg_datapath.sv
hw/rtl/gather_descriptor_generator_unit.sv
verif/tb_top.sv
